// File: hw/rtl/cls_pkg.sv
package cls_pkg;

    localparam int LINE_MAX_DEF = 1024;
    localparam int LEN_W        = 10;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_KEPT = 2'd0,
        KIND_DROP = 2'd1,
        KIND_TERM = 2'd2,
        KIND_SKIP = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]       byte_out;
        t_kind            kind;
        logic             line_end;
        logic [LEN_W-1:0] line_len;
        logic             end_of_run;
    } t_out_beat;

    typedef struct packed {
        logic quote_odd;
        logic in_line;
        logic in_block;
        logic skip_sep;
        logic term_next;
    } t_flags;

endpackage

// File: hw/rtl/cls_classify.sv
module cls_classify #(
    parameter int LINE_MAX = cls_pkg::LINE_MAX_DEF
) (
    input  logic [7:0]                  i_b,
    input  logic                        i_has_next,
    input  logic [7:0]                  i_nx,
    input  cls_pkg::t_flags             i_st,
    input  logic [$clog2(LINE_MAX)-1:0] i_cnt,
    output cls_pkg::t_flags             o_st,
    output logic [$clog2(LINE_MAX)-1:0] o_cnt,
    output cls_pkg::t_out_beat          o_res
);
    import cls_pkg::*;

    localparam int             CW      = $clog2(LINE_MAX);
    localparam logic [CW-1:0]  CNT_MAX = CW'(LINE_MAX - 1);

    function automatic logic is_sep(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR) || (b == CH_SEMI) ||
               ((b != 8'h00) && (b <= CH_SPACE));
    endfunction

    // report the count through the fixed-width length field
    function automatic logic [LEN_W-1:0] len_of(input logic [CW-1:0] c);
        logic [CW+LEN_W-1:0] wide;
        wide = {{LEN_W{1'b0}}, c};
        return wide[LEN_W-1:0];
    endfunction

    always_comb begin : p_cls
        t_flags        st;
        logic [CW-1:0] cnt;
        t_out_beat     res;
        logic          done;
        logic          term;
        logic          closing;

        st      = i_st;
        cnt     = i_cnt;
        done    = 1'b0;
        term    = 1'b0;
        closing = 1'b0;
        res.byte_out   = i_b;
        res.kind       = KIND_KEPT;
        res.line_end   = 1'b0;
        res.line_len   = '0;
        res.end_of_run = 1'b0;

        if (st.skip_sep) begin
            if (is_sep(i_b)) begin
                res.kind = KIND_SKIP;
                done     = 1'b1;
            end else begin
                st.skip_sep = 1'b0;
            end
        end

        if (!done) begin
            if (st.term_next) begin
                st.term_next = 1'b0;
                term         = 1'b1;
            end else begin
                if (i_b == CH_QUOTE) begin
                    st.quote_odd = !st.quote_odd;
                end
                if (!st.quote_odd) begin
                    if (i_has_next) begin
                        if (!st.in_block && i_b == CH_SLASH && i_nx == CH_SLASH) begin
                            st.in_line = 1'b1;
                        end else if (!st.in_line && i_b == CH_SLASH && i_nx == CH_STAR) begin
                            st.in_block = 1'b1;
                        end else if (st.in_block && i_b == CH_STAR && i_nx == CH_SLASH) begin
                            // the closing slash becomes the terminator
                            st.in_block  = 1'b0;
                            st.term_next = 1'b1;
                            closing      = 1'b1;
                        end
                    end
                    if (!closing && !st.in_line && !st.in_block && i_b == CH_SEMI) begin
                        term = 1'b1;
                    end
                end
                if (!closing && !term && !st.in_block && !st.quote_odd &&
                    (i_b == CH_LF || i_b == CH_CR)) begin
                    st.in_line = 1'b0;
                    term       = 1'b1;
                end
            end

            if (term) begin
                res.kind     = KIND_TERM;
                res.line_end = 1'b1;
                res.line_len = len_of(cnt);
                st.quote_odd = 1'b0;
                st.skip_sep  = 1'b1;
                cnt          = '0;
            end else if (cnt < CNT_MAX) begin
                cnt          = CW'(cnt + 1'b1);
                res.kind     = KIND_KEPT;
                res.line_len = len_of(cnt);
            end else begin
                res.kind     = KIND_DROP;
                res.line_len = len_of(cnt);
            end
        end

        o_st  = st;
        o_cnt = cnt;
        o_res = res;
    end

endmodule

// File: hw/rtl/cls_fifo.sv
module cls_fifo (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push0,
    input  logic                                   i_push1,
    input  cls_pkg::t_out_beat                     i_wdata0,
    input  cls_pkg::t_out_beat                     i_wdata1,
    input  logic                                   i_stall,
    output logic                                   o_valid,
    output cls_pkg::t_out_beat                     o_rdata,
    output logic [$clog2(cls_pkg::FIFO_DEPTH+1)-1:0] o_count
);
    import cls_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_out_beat       r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   w_wr_ptr1;
    logic            w_pop;
    logic [1:0]      w_push_n;

    assign w_wr_ptr1 = PW'(r_wr_ptr + 1'b1);
    assign w_pop     = (r_count != '0) && !i_stall;
    assign w_push_n  = {1'b0, i_push0} + {1'b0, i_push1};

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_wdata0;
        end
        if (i_push1) begin
            r_mem[w_wr_ptr1] <= i_wdata1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= PW'(r_wr_ptr + w_push_n);
            if (w_pop) begin
                r_rd_ptr <= PW'(r_rd_ptr + 1'b1);
            end
            r_count <= CW'(r_count + w_push_n - {1'b0, w_pop});
        end
    end

    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: hw/rtl/command_line_splitter.sv
// An input beat is registered, then held until the next beat is its lookahead;
// a last beat is classified at once and may push two results. One input beat per
// cycle enters unless o_in_stall; one result per cycle leaves unless i_out_stall.
// The input stall rises when the four-entry output queue could not take two more.
// Reset (synchronous, active low) clears the held byte, comment/quote state,
// the line count and the output queue.
module command_line_splitter #(
    parameter int LINE_MAX = cls_pkg::LINE_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cls_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cls_pkg::t_out_beat o_out_data
);
    import cls_pkg::*;

    localparam int CW  = $clog2(LINE_MAX);
    localparam int QCW = $clog2(FIFO_DEPTH + 1);

    logic            r_in_valid;
    t_in_beat        r_in;
    logic [7:0]      r_held_byte;
    logic            r_held_valid;
    t_flags          r_flags;
    logic [CW-1:0]   r_cnt;

    t_flags          w_st_a;
    logic [CW-1:0]   w_cnt_a;
    t_out_beat       w_res_a;
    t_flags          w_st1;
    logic [CW-1:0]   w_cnt1;
    t_out_beat       w_res_b;
    t_out_beat       w_beat_a;
    t_out_beat       w_beat_b;
    logic            w_push0;
    logic            w_push1;
    t_out_beat       w_wdata0;
    logic [QCW-1:0]  w_count;
    logic [QCW:0]    w_fill;
    logic            w_accept;

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    // held byte with the new byte as lookahead
    cls_classify #(.LINE_MAX(LINE_MAX)) u_cls_held (
        .i_b        (r_held_byte),
        .i_has_next (1'b1),
        .i_nx       (r_in.ch),
        .i_st       (r_flags),
        .i_cnt      (r_cnt),
        .o_st       (w_st_a),
        .o_cnt      (w_cnt_a),
        .o_res      (w_res_a)
    );

    assign w_st1  = r_held_valid ? w_st_a  : r_flags;
    assign w_cnt1 = r_held_valid ? w_cnt_a : r_cnt;

    // final byte of the text, no lookahead
    cls_classify #(.LINE_MAX(LINE_MAX)) u_cls_last (
        .i_b        (r_in.ch),
        .i_has_next (1'b0),
        .i_nx       (8'h00),
        .i_st       (w_st1),
        .i_cnt      (w_cnt1),
        .o_st       (),
        .o_cnt      (),
        .o_res      (w_res_b)
    );

    always_comb begin
        w_beat_a            = w_res_a;
        w_beat_a.end_of_run = !r_in.last;
        w_beat_b            = w_res_b;
        w_beat_b.end_of_run = 1'b1;
        if (w_res_b.kind != KIND_TERM && w_res_b.kind != KIND_SKIP) begin
            w_beat_b.line_end = 1'b1;
        end
    end

    assign w_push0  = r_in_valid && (r_held_valid || r_in.last);
    assign w_push1  = r_in_valid && r_held_valid && r_in.last;
    assign w_wdata0 = r_held_valid ? w_beat_a : w_beat_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_flags      <= '0;
            r_cnt        <= '0;
        end else if (r_in_valid) begin
            if (r_in.last) begin
                // end of text: drop all line and comment state
                r_held_byte  <= '0;
                r_held_valid <= 1'b0;
                r_flags      <= '0;
                r_cnt        <= '0;
            end else begin
                r_held_byte  <= r_in.ch;
                r_held_valid <= 1'b1;
                r_flags      <= w_st1;
                r_cnt        <= w_cnt1;
            end
        end
    end

    cls_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push0  (w_push0),
        .i_push1  (w_push1),
        .i_wdata0 (w_wdata0),
        .i_wdata1 (w_beat_b),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_rdata  (o_out_data),
        .o_count  (w_count)
    );

    // leave room for the two beats a new item may bring
    assign w_fill     = {1'b0, w_count} + {{QCW{1'b0}}, w_push0} + {{QCW{1'b0}}, w_push1};
    assign o_in_stall = (w_fill > (QCW+1)'(FIFO_DEPTH - 2));

    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= QCW'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in.last |=> !r_held_valid && r_cnt == '0 && r_flags == '0)
        else $error("state not cleared after end of text");

    a_skip_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_SKIP |->
            o_out_data.line_len == '0 && !o_out_data.line_end)
        else $error("skipped separator carries a line length or end");

endmodule

// File: verif/cls_split_checker.sv
`timescale 1ns / 100ps

module cls_split_checker #(
    parameter int LINE_MAX = cls_pkg::LINE_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  cls_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  cls_pkg::t_out_beat i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import cls_pkg::*;

    t_out_beat   split_beats_q[$];
    logic [7:0]  held_ch;
    logic        held_ok;
    t_flags      fl;
    int unsigned kept;
    int          fail_n = 0;

    function automatic logic is_sep(input logic [7:0] b);
        return b == CH_LF || b == CH_CR || b == CH_SEMI || (b != 8'h00 && b <= CH_SPACE);
    endfunction

    function automatic t_out_beat make_beat(input logic [7:0] b, input t_kind k,
                                            input logic e, input int unsigned len);
        t_out_beat r;
        r.byte_out   = b;
        r.kind       = k;
        r.line_end   = e;
        r.line_len   = len[LEN_W-1:0];
        r.end_of_run = 1'b0;
        return r;
    endfunction

    task automatic clear_state();
        held_ch = 8'h00;
        held_ok = 1'b0;
        fl      = '0;
        kept    = 0;
    endtask

    task automatic close_line(input logic [7:0] b, output t_out_beat r);
        r            = make_beat(b, KIND_TERM, 1'b1, kept);
        fl.quote_odd = 1'b0;
        kept         = 0;
        fl.skip_sep  = 1'b1;
    endtask

    // Classify one byte; nx is the lookahead byte when has_nx is set.
    task automatic split_char(input logic [7:0] b, input logic has_nx,
                              input logic [7:0] nx, output t_out_beat r);
        logic term;
        logic closing;
        term    = 1'b0;
        closing = 1'b0;
        if (fl.skip_sep) begin
            if (is_sep(b)) begin
                r = make_beat(b, KIND_SKIP, 1'b0, 0);
                return;
            end
            fl.skip_sep = 1'b0;
        end
        if (fl.term_next) begin
            fl.term_next = 1'b0;
            close_line(b, r);
            return;
        end
        if (b == CH_QUOTE)
            fl.quote_odd = !fl.quote_odd;
        if (!fl.quote_odd) begin
            if (has_nx) begin
                if (!fl.in_block && b == CH_SLASH && nx == CH_SLASH) begin
                    fl.in_line = 1'b1;
                end else if (!fl.in_line && b == CH_SLASH && nx == CH_STAR) begin
                    fl.in_block = 1'b1;
                end else if (fl.in_block && b == CH_STAR && nx == CH_SLASH) begin
                    // the slash that follows becomes the terminator
                    fl.in_block  = 1'b0;
                    fl.term_next = 1'b1;
                    closing      = 1'b1;
                end
            end
            if (!closing && !fl.in_line && !fl.in_block && b == CH_SEMI)
                term = 1'b1;
        end
        if (!closing && !term && !fl.in_block && !fl.quote_odd &&
            (b == CH_LF || b == CH_CR)) begin
            fl.in_line = 1'b0;
            term       = 1'b1;
        end
        if (term) begin
            close_line(b, r);
            return;
        end
        if (kept < LINE_MAX - 1) begin
            kept++;
            r = make_beat(b, KIND_KEPT, 1'b0, kept);
        end else begin
            r = make_beat(b, KIND_DROP, 1'b0, kept);
        end
    endtask

    task automatic take_input(input t_in_beat beat);
        t_out_beat r0;
        t_out_beat r1;
        logic      has0;
        has0 = held_ok;
        if (held_ok)
            split_char(held_ch, 1'b1, beat.ch, r0);
        if (beat.last) begin
            split_char(beat.ch, 1'b0, 8'h00, r1);
            if (r1.kind != KIND_TERM && r1.kind != KIND_SKIP)
                r1.line_end = 1'b1;
            r1.end_of_run = 1'b1;
            if (has0)
                split_beats_q.push_back(r0);
            split_beats_q.push_back(r1);
            clear_state();
        end else begin
            held_ch = beat.ch;
            held_ok = 1'b1;
            if (has0) begin
                r0.end_of_run = 1'b1;
                split_beats_q.push_back(r0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (a !== e) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
            fail_n++;
        end
    endtask

    task automatic match_beat(input t_out_beat got);
        t_out_beat want;
        if (split_beats_q.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
            fail_n++;
            return;
        end
        want = split_beats_q.pop_front();
        check_field("byte_out", 16'(want.byte_out), 16'(got.byte_out));
        check_field("kind", 16'(want.kind), 16'(got.kind));
        check_field("line_end", 16'(want.line_end), 16'(got.line_end));
        check_field("line_len", 16'(want.line_len), 16'(got.line_len));
        check_field("end_of_run", 16'(want.end_of_run), 16'(got.end_of_run));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            split_beats_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                take_input(i_in_data);
            if (i_out_valid && !i_out_stall)
                match_beat(i_out_data);
        end
        o_pending    <= split_beats_q.size();
        o_fail_count <= fail_n;
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import cls_pkg::*;

    localparam logic [7:0] SPECIALS [6] = '{CH_SLASH, CH_STAR, CH_QUOTE, CH_SEMI, CH_LF, CH_CR};

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_data;

    int         fail_n;
    int         pend_n;
    int         idle_pct   = 0;
    int         stall_pct  = 0;
    logic       hold_req   = 1'b0;
    logic       hold_seen  = 1'b0;
    int         hold_left  = 0;
    int         items_sent = 0;
    logic [7:0] text_q[$];

    command_line_splitter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    cls_split_checker u_split_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_n),
        .o_pending    (pend_n)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** command_line_splitter: FAILED **");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on each toggle of hold_req.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 80;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_beat(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        in_data.ch   <= ch;
        in_data.last <= last;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_beat(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // Hold the sender until every predicted beat has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pend_n != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_ch(input logic [7:0] b);
        text_q.push_back(b);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic push_word();
        int cnt;
        cnt = $urandom_range(1, 8);
        repeat (cnt) push_ch(8'h61 + 8'($urandom_range(0, 25)));
    endtask

    task automatic add_fragment();
        int sel;
        int cnt;
        sel = $urandom_range(0, 11);
        case (sel)
            0: push_word();
            1: begin
                cnt = $urandom_range(1, 3);
                repeat (cnt) push_ch(8'($urandom_range(1, 32)));
            end
            2: push_ch(CH_SEMI);
            3: begin
                cnt = $urandom_range(0, 2);
                if (cnt != 0)
                    push_ch(CH_CR);
                if (cnt != 1)
                    push_ch(CH_LF);
            end
            4: begin
                push_ch(CH_QUOTE);
                push_word();
                if ($urandom_range(1))
                    push_ch(CH_SEMI);
                if ($urandom_range(1))
                    push_str("//");
                push_word();
                push_ch(CH_QUOTE);
            end
            5: begin
                push_str("//");
                push_word();
                if ($urandom_range(1))
                    push_ch(CH_SEMI);
                push_ch($urandom_range(1) ? CH_LF : CH_CR);
            end
            6: begin
                push_str("/*");
                push_word();
                if ($urandom_range(1))
                    push_ch(CH_SEMI);
                if ($urandom_range(1))
                    push_ch(CH_LF);
                if ($urandom_range(9) == 0)
                    push_ch(CH_QUOTE);
                push_str("*/");
            end
            7: push_ch(CH_QUOTE);
            8: push_ch($urandom_range(1) ? CH_SLASH : CH_STAR);
            9: push_ch(8'($urandom_range(0, 255)));
            10: push_ch($urandom_range(1) ? 8'h00 : 8'($urandom_range(128, 255)));
            default: begin
                push_str(";;");
                push_ch(CH_SPACE);
                push_ch(CH_LF);
            end
        endcase
    endtask

    // Mostly well-formed command text, the rest raw noise.
    task automatic build_buffer();
        int cnt;
        if ($urandom_range(99) < 80) begin
            cnt = $urandom_range(1, 6);
            repeat (cnt) add_fragment();
        end else begin
            cnt = $urandom_range(1, 12);
            repeat (cnt) begin
                if ($urandom_range(3) == 0)
                    push_ch(SPECIALS[$urandom_range(0, 5)]);
                else
                    push_ch(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // One line well past the kept limit, so the tail is dropped.
    task automatic build_long_line();
        int sel;
        repeat (LINE_MAX_DEF + 16) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                push_ch(CH_SPACE);
            else if (sel == 1)
                push_ch(8'($urandom_range(128, 255)));
            else
                push_ch(8'h61 + 8'($urandom_range(0, 25)));
        end
        push_ch(CH_SEMI);
        push_str("z");
    endtask

    initial begin
        int start;
        logic paused;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_ch(8'hFF);
        send_text();
        push_ch(8'h00);
        send_text();
        push_str("a;");
        push_ch(CH_SPACE);
        push_ch(8'h09);
        push_ch(8'h01);
        push_str("b");
        send_text();
        push_str("\";\"x");
        push_ch(CH_LF);
        send_text();
        push_str("/*;*/y");
        send_text();
        push_str("//;");
        push_ch(CH_CR);
        push_str("z");
        send_text();
        push_str("/");
        send_text();
        push_ch(CH_CR);
        send_text();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            if (phase == 0) begin
                // long receiver hold-off while the sender keeps offering
                hold_req <= ~hold_req;
                while (text_q.size() < 40)
                    add_fragment();
                send_text();
                drain();
                build_long_line();
                send_text();
                drain();
            end
            start  = items_sent;
            paused = 1'b0;
            while (items_sent - start < 140) begin
                build_buffer();
                send_text();
                if (!paused && items_sent - start >= 70) begin
                    paused = 1'b1;
                    drain();
                end
            end
            drain();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (fail_n == 0 && pend_n == 0) begin
            $display("** command_line_splitter: PASSED **");
        end else begin
            $display("** command_line_splitter: FAILED **");
        end
        $finish;
    end

endmodule
